// File: rtl/core/mh64_pkg.sv
// Shared types, constants and command format for the streaming MurmurHash64A block.
package mh64_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned TAIL_W = 56;
  localparam int unsigned TCNT_W = 3;
  localparam int unsigned HALF_W = 32;
  localparam int unsigned ADDR_W = 4;

  // Hash constants.
  localparam logic [WORD_W-1:0] MURMUR_MUL   = 64'hc6a4a7935bd1e995;
  localparam int unsigned       MURMUR_SHIFT = 47;
  localparam logic [WORD_W-1:0] DEFAULT_SEED = 64'h00000000c70f6907;

  // Last byte lane of an 8-byte block.
  localparam logic [TCNT_W-1:0] TAIL_LAST = 3'd7;

  // Command queue depth between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 4;

  // The low 64 bits of a 64 by 64 multiply come from three 32 by 32 partial products.
  localparam logic [1:0] MUL_FIRST = 2'd0;
  localparam logic [1:0] MUL_MID   = 2'd1;
  localparam logic [1:0] MUL_LAST  = 2'd2;

  // Configuration register map, indexed by paddr[3].
  typedef enum logic [0:0] {
    REG_TOTAL_LENGTH = 1'b0,
    REG_SEED         = 1'b1
  } mh64_reg_t;

  // Work handed from the front to the back for one input item.
  typedef struct packed {
    logic              start;     // first byte of a message: load initial hash
    logic [WORD_W-1:0] seed;      // seed captured at the first byte
    logic [WORD_W-1:0] tlen;      // total length captured at the first byte
    logic              absorb;    // data holds a full block to mix in
    logic              close;     // last byte: finish and give a result
    logic [WORD_W-1:0] data;      // full block or leftover tail bytes
    logic [WORD_W-1:0] count;     // bytes in the message so far
    logic              mismatch;  // count differs from configured length
  } mh64_cmd_t;

  // Back sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MUL,
    ST_OUT
  } mh64_state_t;

  // Which multiply of the hash schedule is running.
  typedef enum logic [2:0] {
    PH_INIT,
    PH_K1,
    PH_K2,
    PH_HB,
    PH_TAIL,
    PH_F1
  } mh64_phase_t;

endpackage

// File: rtl/core/mh64_if.sv
// Valid/ready channel interfaces for message bytes and finished hash results.
interface mh64_msg_if import mh64_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface mh64_res_if import mh64_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] hash;
  logic [WORD_W-1:0] byte_count;
  logic              length_mismatch;

  modport source (output valid, output hash, output byte_count, output length_mismatch,
                  input ready);
  modport sink   (input valid, input hash, input byte_count, input length_mismatch,
                  output ready);
endinterface

// File: rtl/core/mh64_front.sv
// Front end: accepts message bytes, gathers 8-byte blocks and issues commands.
module mh64_front import mh64_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  mh64_msg_if.sink          msg,
  input  logic [WORD_W-1:0] total_length,
  input  logic [WORD_W-1:0] seed,
  input  logic              q_full,
  output logic              push,
  output mh64_cmd_t         push_cmd
);

  logic              in_message;
  logic [TAIL_W-1:0] pending_block;
  logic [TCNT_W-1:0] pending_count;
  logic [WORD_W-1:0] bytes_seen;

  logic              accept;
  logic [TCNT_W-1:0] cur_cnt;
  logic [TAIL_W-1:0] cur_blk;
  logic [WORD_W-1:0] cur_bytes;
  logic              block_full;
  logic [WORD_W-1:0] merged;

  // A byte is taken whenever the queue has room for whatever it may cause.
  assign msg.ready = !q_full;
  assign accept    = msg.valid && msg.ready;

  // Classify the byte: message start, block completion and message end.
  always_comb begin
    cur_cnt    = in_message ? pending_count : '0;
    cur_blk    = in_message ? pending_block : '0;
    cur_bytes  = (in_message ? bytes_seen : '0) + WORD_W'(1);
    block_full = (cur_cnt == TAIL_LAST);
    merged     = {{(WORD_W-TAIL_W){1'b0}}, cur_blk}
               | ({{(WORD_W-BYTE_W){1'b0}}, msg.data_byte} << {cur_cnt, 3'b000});

    push_cmd.start    = !in_message;
    push_cmd.seed     = seed;
    push_cmd.tlen     = total_length;
    push_cmd.absorb   = block_full;
    push_cmd.close    = msg.last;
    push_cmd.data     = merged;
    push_cmd.count    = cur_bytes;
    push_cmd.mismatch = (cur_bytes != total_length);

    push = accept && (push_cmd.start || block_full || msg.last);
  end

  // Message assembly state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_message    <= 1'b0;
      pending_block <= '0;
      pending_count <= '0;
      bytes_seen    <= '0;
    end else if (accept) begin
      if (msg.last) begin
        in_message    <= 1'b0;
        pending_block <= '0;
        pending_count <= '0;
        bytes_seen    <= '0;
      end else begin
        in_message    <= 1'b1;
        pending_block <= block_full ? '0 : merged[TAIL_W-1:0];
        pending_count <= cur_cnt + TCNT_W'(1);
        bytes_seen    <= cur_bytes;
      end
    end
  end

endmodule

// File: rtl/core/mh64_queue.sv
// Small command queue that decouples the front end from the hash engine.
module mh64_queue import mh64_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  mh64_cmd_t push_cmd,
  input  logic      pop,
  output mh64_cmd_t head,
  output logic      empty,
  output logic      full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  mh64_cmd_t        entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign empty = (fill == '0);
  assign full  = (fill == CNT_W'(DEPTH));
  assign head  = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/core/mh64_back.sv
// Hash engine: runs the MurmurHash64A schedule on one shared 32x32 multiplier.
module mh64_back import mh64_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  mh64_cmd_t head,
  input  logic      empty,
  output logic      pop,
  mh64_res_if.source res
);

  localparam logic [HALF_W-1:0] MUL_LO = MURMUR_MUL[HALF_W-1:0];
  localparam logic [HALF_W-1:0] MUL_HI = MURMUR_MUL[WORD_W-1:HALF_W];

  mh64_state_t       state, state_next;
  mh64_phase_t       phase, phase_next;
  logic [1:0]        mcnt, mcnt_next;
  logic              do_start, do_start_next;
  logic              do_absorb, do_absorb_next;
  logic              do_close, do_close_next;
  mh64_cmd_t         cmd, cmd_next;
  logic [WORD_W-1:0] h, h_next;
  logic [WORD_W-1:0] x, x_next;
  logic [WORD_W-1:0] p, p_next;
  logic [WORD_W-1:0] fin, fin_next;
  logic              res_valid, res_valid_next;
  logic [WORD_W-1:0] res_hash, res_hash_next;
  logic [WORD_W-1:0] res_count, res_count_next;
  logic              res_mismatch, res_mismatch_next;

  logic [HALF_W-1:0] mul_a;
  logic [HALF_W-1:0] mul_b;
  logic [WORD_W-1:0] partial;
  logic [WORD_W-1:0] prod;

  // One partial product per cycle; the low 64 bits need three of them.
  always_comb begin
    case (mcnt)
      MUL_FIRST: begin
        mul_a = x[HALF_W-1:0];
        mul_b = MUL_LO;
      end
      MUL_MID: begin
        mul_a = x[WORD_W-1:HALF_W];
        mul_b = MUL_LO;
      end
      default: begin
        mul_a = x[HALF_W-1:0];
        mul_b = MUL_HI;
      end
    endcase
    partial = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
    prod    = (mcnt == MUL_FIRST) ? partial : p + {partial[HALF_W-1:0], {HALF_W{1'b0}}};
  end

  assign res.valid           = res_valid;
  assign res.hash            = res_hash;
  assign res.byte_count      = res_count;
  assign res.length_mismatch = res_mismatch;

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_next        = state;
    phase_next        = phase;
    mcnt_next         = mcnt;
    do_start_next     = do_start;
    do_absorb_next    = do_absorb;
    do_close_next     = do_close;
    cmd_next          = cmd;
    h_next            = h;
    x_next            = x;
    p_next            = p;
    fin_next          = fin;
    res_valid_next    = res_valid && !res.ready;
    res_hash_next     = res_hash;
    res_count_next    = res_count;
    res_mismatch_next = res_mismatch;
    pop               = 1'b0;

    case (state)
      ST_IDLE: begin
        if (!empty) begin
          pop            = 1'b1;
          cmd_next       = head;
          do_start_next  = head.start;
          do_absorb_next = head.absorb;
          do_close_next  = head.close;
          state_next     = ST_DISPATCH;
        end
      end

      // Pick the next piece of work of the current command, in hash order.
      ST_DISPATCH: begin
        mcnt_next = MUL_FIRST;
        if (do_start) begin
          do_start_next = 1'b0;
          x_next        = cmd.tlen;
          phase_next    = PH_INIT;
          state_next    = ST_MUL;
        end else if (do_absorb) begin
          do_absorb_next = 1'b0;
          x_next         = cmd.data;
          phase_next     = PH_K1;
          state_next     = ST_MUL;
        end else if (do_close) begin
          do_close_next = 1'b0;
          state_next    = ST_MUL;
          if (!cmd.absorb) begin
            x_next     = h ^ cmd.data;
            phase_next = PH_TAIL;
          end else begin
            x_next     = h ^ (h >> MURMUR_SHIFT);
            phase_next = PH_F1;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end

      // Multiply x by the hash constant, then chain to the next step.
      ST_MUL: begin
        p_next    = prod;
        mcnt_next = mcnt + 2'd1;
        if (mcnt == MUL_LAST) begin
          mcnt_next = MUL_FIRST;
          case (phase)
            PH_INIT: begin
              h_next     = cmd.seed ^ prod;
              state_next = ST_DISPATCH;
            end
            PH_K1: begin
              x_next     = prod ^ (prod >> MURMUR_SHIFT);
              phase_next = PH_K2;
            end
            PH_K2: begin
              x_next     = h ^ prod;
              phase_next = PH_HB;
            end
            PH_HB: begin
              h_next     = prod;
              state_next = ST_DISPATCH;
            end
            PH_TAIL: begin
              x_next     = prod ^ (prod >> MURMUR_SHIFT);
              phase_next = PH_F1;
            end
            default: begin
              fin_next   = prod ^ (prod >> MURMUR_SHIFT);
              state_next = ST_OUT;
            end
          endcase
        end
      end

      // Hand the finished hash to the output register once it is free.
      ST_OUT: begin
        if (!res_valid || res.ready) begin
          res_valid_next    = 1'b1;
          res_hash_next     = fin;
          res_count_next    = cmd.count;
          res_mismatch_next = cmd.mismatch;
          state_next        = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_INIT;
      mcnt      <= MUL_FIRST;
      do_start  <= 1'b0;
      do_absorb <= 1'b0;
      do_close  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      mcnt      <= mcnt_next;
      do_start  <= do_start_next;
      do_absorb <= do_absorb_next;
      do_close  <= do_close_next;
      res_valid <= res_valid_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cmd          <= cmd_next;
    h            <= h_next;
    x            <= x_next;
    p            <= p_next;
    fin          <= fin_next;
    res_hash     <= res_hash_next;
    res_count    <= res_count_next;
    res_mismatch <= res_mismatch_next;
  end

endmodule

// File: rtl/core/murmur64a_stream_hash.sv
// Top level of the streaming MurmurHash64A block with its configuration registers.
//
// Usage: message bytes arrive on the msg channel, one item per byte, in order,
// with last set on the final byte. One result item per message leaves on the
// res channel: the 64-bit hash, the byte count and a length mismatch flag.
// total_length (address 0x0) and seed (address 0x8) are for the user to write over
// the APB port only while no message is being processed; the block does not enforce
// this. The values seen at a message's first byte set its initial hash, and the
// mismatch check uses total_length as it stands at the last byte.
// Throughput: the front takes one byte per cycle while the command queue has
// room. Each 64-bit product is three partial products on the single 32x32
// multiplier; an 8-byte block takes three such products and a message start
// one, plus ST_IDLE to fetch the command and ST_DISPATCH to find it finished.
// The queue lets the front keep taking bytes while the engine is still busy.
// The last byte's command runs any start and block products, then the tail and
// final products (tail skipped when it completes a block), then ST_OUT.
// Reset empties the queue, closes any open message and restores the default
// seed and a zero length. A stalled res channel holds its item; the engine
// then waits with its next result and the queue fills until msg stalls too.
module murmur64a_stream_hash import mh64_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  mh64_msg_if.sink          msg,
  mh64_res_if.source        res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [WORD_W-1:0] pwdata,
  output logic [WORD_W-1:0] prdata,
  output logic              pready
);

  logic [WORD_W-1:0] total_length;
  logic [WORD_W-1:0] seed;
  mh64_reg_t         reg_sel;

  logic      q_push;
  mh64_cmd_t q_push_cmd;
  logic      q_pop;
  mh64_cmd_t q_head;
  logic      q_empty;
  logic      q_full;

  // Register decode: each register occupies an 8-byte slot.
  assign reg_sel = mh64_reg_t'(paddr[3]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_length <= '0;
      seed         <= DEFAULT_SEED;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_TOTAL_LENGTH: total_length <= pwdata;
        REG_SEED:         seed         <= pwdata;
        default: ;
      endcase
    end
  end

  // Read-back of the configuration registers.
  always_comb begin
    case (reg_sel)
      REG_TOTAL_LENGTH: prdata = total_length;
      REG_SEED:         prdata = seed;
      default:          prdata = '0;
    endcase
  end

  mh64_front u_front (
    .clk          (clk),
    .rst          (rst),
    .msg          (msg),
    .total_length (total_length),
    .seed         (seed),
    .q_full       (q_full),
    .push         (q_push),
    .push_cmd     (q_push_cmd)
  );

  mh64_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  mh64_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (q_head),
    .empty (q_empty),
    .pop   (q_pop),
    .res   (res)
  );

endmodule

// File: rtl/core/mh64_checker.sv
// Port-level checks for the streaming hash block, bound to its top level.
module mh64_checker import mh64_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input logic [WORD_W-1:0] res_hash,
  input logic [WORD_W-1:0] res_byte_count,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [WORD_W-1:0] pwdata,
  input logic [WORD_W-1:0] prdata
);

  // A stalled result keeps its hash.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_hash))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_res_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // Every message holds at least the byte marked last.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_byte_count != '0)
    else $error("result with zero byte count");

  // A seed write reads back on the next cycle.
  a_seed_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && paddr[3] ##1 !rst && paddr[3]
      |-> prdata == $past(pwdata))
    else $error("seed read-back differs from the value written");

endmodule

bind murmur64a_stream_hash mh64_checker u_mh64_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_hash       (res.hash),
  .res_byte_count (res.byte_count),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite),
  .paddr          (paddr),
  .pwdata         (pwdata),
  .prdata         (prdata)
);
